// ===== sv/ihbf_pkg.sv =====
`default_nettype none
package ihbf_pkg;

  localparam int MAX_MTU     = 1500;
  localparam int MIN_MTU     = 28;
  localparam int MTU_RESET   = 1500;
  localparam int HDR_LEN     = 20;
  localparam int MAX_PAYLOAD = 65515;
  localparam int CKS_WORDS   = 10;

  localparam int MTU_W = 11;
  localparam int IDX_W = 5;
  localparam int CKS_W = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  localparam int CFG_AW = 3;
  localparam logic REG_MTU = 1'b0;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [7:0] VER_IHL = 8'h45;
  localparam logic [7:0] TOS     = 8'h00;
  localparam logic [7:0] TTL     = 8'd64;

  typedef enum logic [1:0] {
    JOB_HDR_ONLY,
    JOB_HDR_BYTE,
    JOB_BYTE
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic        flast;
    logic [47:0] mac;
    logic [15:0] total;
    logic [15:0] ident;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } job_t;

endpackage
`default_nettype wire

// ===== sv/ihbf_in_if.sv =====
`default_nettype none
interface ihbf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  protocol_number;
  logic [47:0] mac_da;
  logic [31:0] dest_ip;
  logic [31:0] src_ip;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;

  modport source (
    output valid, opcode, protocol_number, mac_da, dest_ip, src_ip,
           payload_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, protocol_number, mac_da, dest_ip, src_ip,
           payload_length, data_byte,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/ihbf_out_if.sv =====
`default_nettype none
interface ihbf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic [47:0] frame_mac;
  logic        run_last;

  modport source (
    output valid, frame_byte, frame_last, frame_mac, run_last,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, frame_last, frame_mac, run_last,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/ihbf_front.sv =====
`default_nettype none
module ihbf_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  ihbf_in_if.sink                        in_bus,
  input  wire logic [ihbf_pkg::MTU_W-1:0] mtu,
  input  wire logic                      q_full,
  output      logic                      push,
  output      ihbf_pkg::job_t            push_job
);

  logic [15:0] ident_r, ident_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [10:0] fill_r, fill_nxt;
  logic [12:0] off_r, off_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [31:0] dip_r, dip_nxt;
  logic [31:0] sip_r, sip_nxt;

  logic [10:0] eff_mtu;
  logic [10:0] fd_sub;
  logic [10:0] fd;
  logic [15:0] len;
  logic [16:0] start_rem;
  logic        last_frag;
  logic [15:0] rem_dec;
  logic [10:0] fill_inc;
  logic        accept;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    eff_mtu = mtu;
    if (mtu < 11'(ihbf_pkg::MIN_MTU)) begin
      eff_mtu = 11'(ihbf_pkg::MIN_MTU);
    end
    if (mtu > 11'(ihbf_pkg::MAX_MTU)) begin
      eff_mtu = 11'(ihbf_pkg::MAX_MTU);
    end
    fd_sub    = eff_mtu - 11'(ihbf_pkg::HDR_LEN);
    fd        = {fd_sub[10:3], 3'b000};
    len       = (in_bus.payload_length > 16'(ihbf_pkg::MAX_PAYLOAD)) ?
                16'(ihbf_pkg::MAX_PAYLOAD) : in_bus.payload_length;
    start_rem = {1'b0, rem_r} + 17'(fill_r);
    last_frag = (start_rem + 17'(ihbf_pkg::HDR_LEN)) <= 17'(eff_mtu);
    rem_dec   = rem_r - 16'd1;
    fill_inc  = fill_r + 11'd1;
  end

  always_comb begin
    ident_nxt = ident_r;
    rem_nxt   = rem_r;
    fill_nxt  = fill_r;
    off_nxt   = off_r;
    proto_nxt = proto_r;
    mac_nxt   = mac_r;
    dip_nxt   = dip_r;
    sip_nxt   = sip_r;
    push      = 1'b0;

    push_job       = '0;
    push_job.kind  = ihbf_pkg::JOB_BYTE;
    push_job.data  = in_bus.data_byte;
    push_job.mac   = mac_r;
    push_job.ident = ident_r;
    push_job.proto = proto_r;
    push_job.src   = sip_r;
    push_job.dst   = dip_r;
    push_job.total = 16'(ihbf_pkg::HDR_LEN) + (last_frag ? rem_r : 16'(fd));
    push_job.frag  = {2'b00, !last_frag, off_r};

    if (accept) begin
      if (in_bus.opcode == ihbf_pkg::OP_START) begin
        proto_nxt = in_bus.protocol_number;
        mac_nxt   = in_bus.mac_da;
        dip_nxt   = in_bus.dest_ip;
        sip_nxt   = in_bus.src_ip;
        rem_nxt   = len;
        fill_nxt  = '0;
        off_nxt   = '0;
        if (len == 16'd0) begin
          // empty packet: one bare header frame
          push           = 1'b1;
          push_job.kind  = ihbf_pkg::JOB_HDR_ONLY;
          push_job.flast = 1'b1;
          push_job.mac   = in_bus.mac_da;
          push_job.proto = in_bus.protocol_number;
          push_job.src   = in_bus.src_ip;
          push_job.dst   = in_bus.dest_ip;
          push_job.total = 16'(ihbf_pkg::HDR_LEN);
          push_job.frag  = '0;
          ident_nxt      = ident_r + 16'd1;
        end
      end else if (rem_r != 16'd0) begin
        push          = 1'b1;
        push_job.kind = (fill_r == 11'd0) ? ihbf_pkg::JOB_HDR_BYTE : ihbf_pkg::JOB_BYTE;
        rem_nxt       = rem_dec;
        fill_nxt      = fill_inc;
        if (rem_dec == 16'd0) begin
          push_job.flast = 1'b1;
          fill_nxt       = '0;
          off_nxt        = '0;
          ident_nxt      = ident_r + 16'd1;
        end else if (!last_frag && (fill_inc >= fd)) begin
          push_job.flast = 1'b1;
          off_nxt        = off_r + 13'(fill_inc >> 3);
          fill_nxt       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= '0;
      rem_r   <= '0;
      fill_r  <= '0;
      off_r   <= '0;
      proto_r <= '0;
      mac_r   <= '0;
      dip_r   <= '0;
      sip_r   <= '0;
    end else begin
      ident_r <= ident_nxt;
      rem_r   <= rem_nxt;
      fill_r  <= fill_nxt;
      off_r   <= off_nxt;
      proto_r <= proto_nxt;
      mac_r   <= mac_nxt;
      dip_r   <= dip_nxt;
      sip_r   <= sip_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ihbf_queue.sv =====
`default_nettype none
module ihbf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ihbf_pkg::job_t push_job,
  output      logic           full,
  input  wire logic           pop,
  output      logic           head_valid,
  output      ihbf_pkg::job_t head
);

  ihbf_pkg::job_t               mem_r [ihbf_pkg::QUEUE_DEPTH];
  logic [ihbf_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ihbf_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ihbf_pkg::QAW:0]       cnt_r, cnt_nxt;

  assign full       = (cnt_r == (ihbf_pkg::QAW+1)'(ihbf_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + ihbf_pkg::QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + ihbf_pkg::QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (ihbf_pkg::QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (ihbf_pkg::QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ihbf_back.sv =====
`default_nettype none
module ihbf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           head_valid,
  input  wire ihbf_pkg::job_t head,
  output      logic           pop,
  ihbf_out_if.source          out_bus
);

  logic [ihbf_pkg::IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [ihbf_pkg::CKS_W-1:0] cks_idx_r, cks_idx_nxt;
  logic [15:0]                sum_r, sum_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r, out_byte_nxt;
  logic                       out_flast_r, out_flast_nxt;
  logic [47:0]                out_mac_r, out_mac_nxt;
  logic                       out_rlast_r, out_rlast_nxt;

  logic [15:0] word;
  logic [16:0] wsum;
  logic [15:0] cks;
  logic [7:0]  hdr_byte;
  logic [7:0]  res_byte;
  logic        is_hdr;
  logic        cks_done;
  logic        cks_wait;
  logic        last_res;
  logic        out_free;
  logic        produce;

  // one header word per cycle into the running one's-complement sum
  always_comb begin
    case (cks_idx_r)
      4'd0:    word = {ihbf_pkg::VER_IHL, ihbf_pkg::TOS};
      4'd1:    word = head.total;
      4'd2:    word = head.ident;
      4'd3:    word = head.frag;
      4'd4:    word = {ihbf_pkg::TTL, head.proto};
      4'd6:    word = head.src[31:16];
      4'd7:    word = head.src[15:0];
      4'd8:    word = head.dst[31:16];
      4'd9:    word = head.dst[15:0];
      default: word = 16'h0000;
    endcase
    wsum = {1'b0, sum_r} + {1'b0, word};
    cks  = ~sum_r;
  end

  always_comb begin
    case (byte_idx_r)
      5'd0:    hdr_byte = ihbf_pkg::VER_IHL;
      5'd1:    hdr_byte = ihbf_pkg::TOS;
      5'd2:    hdr_byte = head.total[15:8];
      5'd3:    hdr_byte = head.total[7:0];
      5'd4:    hdr_byte = head.ident[15:8];
      5'd5:    hdr_byte = head.ident[7:0];
      5'd6:    hdr_byte = head.frag[15:8];
      5'd7:    hdr_byte = head.frag[7:0];
      5'd8:    hdr_byte = ihbf_pkg::TTL;
      5'd9:    hdr_byte = head.proto;
      5'd10:   hdr_byte = cks[15:8];
      5'd11:   hdr_byte = cks[7:0];
      5'd12:   hdr_byte = head.src[31:24];
      5'd13:   hdr_byte = head.src[23:16];
      5'd14:   hdr_byte = head.src[15:8];
      5'd15:   hdr_byte = head.src[7:0];
      5'd16:   hdr_byte = head.dst[31:24];
      5'd17:   hdr_byte = head.dst[23:16];
      5'd18:   hdr_byte = head.dst[15:8];
      5'd19:   hdr_byte = head.dst[7:0];
      default: hdr_byte = head.data;
    endcase
  end

  always_comb begin
    is_hdr   = (head.kind != ihbf_pkg::JOB_BYTE);
    cks_done = (cks_idx_r == ihbf_pkg::CKS_W'(ihbf_pkg::CKS_WORDS));
    cks_wait = is_hdr && (byte_idx_r >= 5'd10) && !cks_done;
    last_res = (head.kind == ihbf_pkg::JOB_BYTE) ||
               ((head.kind == ihbf_pkg::JOB_HDR_ONLY) &&
                (byte_idx_r == ihbf_pkg::IDX_W'(ihbf_pkg::HDR_LEN - 1))) ||
               ((head.kind == ihbf_pkg::JOB_HDR_BYTE) &&
                (byte_idx_r == ihbf_pkg::IDX_W'(ihbf_pkg::HDR_LEN)));
    res_byte = (head.kind == ihbf_pkg::JOB_BYTE) ? head.data : hdr_byte;
    out_free = !out_valid_r || out_bus.ready;
    produce  = head_valid && out_free && !cks_wait;
    pop      = produce && last_res;

    byte_idx_nxt = byte_idx_r;
    if (pop) begin
      byte_idx_nxt = '0;
    end else if (produce) begin
      byte_idx_nxt = byte_idx_r + ihbf_pkg::IDX_W'(1);
    end

    cks_idx_nxt = cks_idx_r;
    sum_nxt     = sum_r;
    if (pop) begin
      cks_idx_nxt = '0;
      sum_nxt     = '0;
    end else if (head_valid && !cks_done) begin
      cks_idx_nxt = cks_idx_r + ihbf_pkg::CKS_W'(1);
      sum_nxt     = wsum[15:0] + 16'(wsum[16]);
    end

    out_valid_nxt = produce || (out_valid_r && !out_bus.ready);
    out_byte_nxt  = out_byte_r;
    out_flast_nxt = out_flast_r;
    out_mac_nxt   = out_mac_r;
    out_rlast_nxt = out_rlast_r;
    if (produce) begin
      out_byte_nxt  = res_byte;
      out_flast_nxt = last_res && head.flast;
      out_mac_nxt   = head.mac;
      out_rlast_nxt = last_res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.frame_byte = out_byte_r;
  assign out_bus.frame_last = out_flast_r;
  assign out_bus.frame_mac  = out_mac_r;
  assign out_bus.run_last   = out_rlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= '0;
      cks_idx_r   <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      byte_idx_r  <= byte_idx_nxt;
      cks_idx_r   <= cks_idx_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_flast_r <= out_flast_nxt;
    out_mac_r   <= out_mac_nxt;
    out_rlast_r <= out_rlast_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/ipv4_header_builder_fragmenter_unit.sv =====
// Path: a payload byte request is written into the job queue at its accepting edge and
//   then registered onto out_bus; a fragment's first request puts out 20 header bytes first.
// Throughput: one request and one output byte per cycle while out_bus.ready is high; a
//   fragment header adds 20 output bytes, the 4-entry job queue holds the header job and
//   three more requests meanwhile, then the input stalls until the back end catches up.
// Reset: synchronous, active low; clears queue, counters, packet state; mtu returns to 1500.
`default_nettype none
module ipv4_header_builder_fragmenter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ihbf_in_if.sink                          in_bus,
  ihbf_out_if.source                       out_bus,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [ihbf_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output      logic [31:0]                 cfg_prdata,
  output      logic                        cfg_pready
);

  // mtu register: frame size limit, header included; clamped in the front end
  logic [ihbf_pkg::MTU_W-1:0] mtu_r, mtu_nxt;
  logic                       cfg_wr;

  // front -> queue -> back
  logic           q_push;
  ihbf_pkg::job_t q_push_job;
  logic           q_full;
  logic           q_pop;
  logic           q_head_valid;
  ihbf_pkg::job_t q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == ihbf_pkg::REG_MTU);
  assign cfg_prdata = (cfg_paddr[2] == ihbf_pkg::REG_MTU) ?
                      {{(32-ihbf_pkg::MTU_W){1'b0}}, mtu_r} : 32'h0;

  always_comb begin
    mtu_nxt = cfg_wr ? cfg_pwdata[ihbf_pkg::MTU_W-1:0] : mtu_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r <= ihbf_pkg::MTU_W'(ihbf_pkg::MTU_RESET);
    end else begin
      mtu_r <= mtu_nxt;
    end
  end

  // Front end: take requests, track packet and fragment state, and
  // hand one job per result-producing request to the queue.
  ihbf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .mtu      (mtu_r),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_push_job)
  );

  // Job queue: lets header emission stall the back end without
  // stalling the input for a few requests.
  ihbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back end: serialize header and payload bytes, folding the header
  // checksum in while the first header bytes go out.
  ihbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_bus    (out_bus)
  );

`ifndef SYNTHESIS
  // never write a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue overflow");

  // retire only a present job
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("pop from empty job queue");

  // retiring a job puts its final result on the output
  a_pop_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_bus.valid && out_bus.run_last))
    else $error("job retired without run_last result");
`endif

endmodule
`default_nettype wire
